// File: rtl/sfc_pkg.sv
package sfc_pkg;

    localparam int RAW_W   = 16;
    localparam int CHK_W   = 8;
    localparam int VAL_W   = 15;
    localparam int CRC_W   = RAW_W + CHK_W;
    localparam int GAIN_W  = 15;
    localparam int PROD_W  = RAW_W + GAIN_W;

    localparam logic [CRC_W-1:0]  CRC_DIVISOR = 24'h988000;
    localparam logic [RAW_W-1:0]  STATUS_MASK = 16'hFFFC;
    localparam logic [GAIN_W-1:0] TEMP_GAIN   = 15'd17572;
    localparam logic [GAIN_W-1:0] HUM_GAIN    = 15'd12500;
    localparam logic [VAL_W:0]    TEMP_OFFSET = 16'd4685;
    localparam logic [VAL_W:0]    HUM_OFFSET  = 16'd600;

    typedef enum logic {
        OP_TEMP = 1'b0,
        OP_HUM  = 1'b1
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [RAW_W-1:0] raw_word;
        logic [CHK_W-1:0] check_byte;
        logic             bus_error;
    } t_in_beat;

    typedef struct packed {
        logic signed [VAL_W-1:0] scaled_value;
        logic                    valid_res;
        logic [RAW_W-1:0]        masked_raw;
    } t_out_beat;

endpackage

// File: rtl/sfc_if.sv
interface sfc_in_if;
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic [sfc_pkg::RAW_W-1:0]    raw_word;
    logic [sfc_pkg::CHK_W-1:0]    check_byte;
    logic                         bus_error;

    modport source (output valid, output op, output raw_word, output check_byte,
                    output bus_error, input ready);
    modport sink   (input valid, input op, input raw_word, input check_byte,
                    input bus_error, output ready);
endinterface

interface sfc_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [sfc_pkg::VAL_W-1:0]  scaled_value;
    logic                              valid_res;
    logic [sfc_pkg::RAW_W-1:0]         masked_raw;

    modport source (output valid, output scaled_value, output valid_res,
                    output masked_raw, input ready);
    modport sink   (input valid, input scaled_value, input valid_res,
                    input masked_raw, output ready);
endinterface

// File: rtl/sfc_crc.sv
module sfc_crc (
    input  logic [sfc_pkg::RAW_W-1:0] i_raw_word,
    input  logic [sfc_pkg::CHK_W-1:0] i_check_byte,
    output logic                      o_crc_ok
);
    import sfc_pkg::*;

    // long division, one quotient bit per step; linear so it folds into xor trees
    always_comb begin
        logic [CRC_W-1:0] rem;
        logic [CRC_W-1:0] div;
        rem = {i_raw_word, i_check_byte};
        div = CRC_DIVISOR;
        for (int i = 0; i < RAW_W; i++) begin
            if (rem[CRC_W-1-i]) begin
                rem = rem ^ div;
            end
            div = div >> 1;
        end
        o_crc_ok = (rem == '0);
    end

endmodule

// File: rtl/sfc_scale.sv
module sfc_scale (
    input  sfc_pkg::t_op                     i_op,
    input  logic [sfc_pkg::RAW_W-1:0]        i_masked,
    output logic signed [sfc_pkg::VAL_W-1:0] o_value
);
    import sfc_pkg::*;

    logic [GAIN_W-1:0] gain;
    logic [VAL_W:0]    offset;
    logic [PROD_W-1:0] prod;
    logic [VAL_W-1:0]  quot;
    logic [VAL_W:0]    diff;

    always_comb begin
        case (i_op)
            OP_TEMP: begin
                gain   = TEMP_GAIN;
                offset = TEMP_OFFSET;
            end
            OP_HUM: begin
                gain   = HUM_GAIN;
                offset = HUM_OFFSET;
            end
            default: begin
                gain   = TEMP_GAIN;
                offset = TEMP_OFFSET;
            end
        endcase
    end

    assign prod = PROD_W'(i_masked) * PROD_W'(gain);
    // floor of a non-negative product is just the upper bits
    assign quot = prod[PROD_W-1 -: VAL_W];
    assign diff = {1'b0, quot} - offset;
    assign o_value = $signed(diff[VAL_W-1:0]);

endmodule

// File: rtl/sensor_frame_crc_check_convert.sv
// channel | dir | beat payload
// i_in    | in  | op, raw_word[15:0], check_byte[7:0], bus_error
// o_out   | out | scaled_value[14:0] signed, valid_res, masked_raw[15:0]
//
// two register stages: input register, then crc check and scaling into the
// result register. one beat per cycle sustained while the output takes
// results; the single 16x15 multiply sets the path.
// reset (synchronous, active low) empties both stages.
// a stalled result holds the output; the input register still takes a beat
// while it is free, and ready drops only when both stages are full.
module sensor_frame_crc_check_convert (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sfc_in_if.sink    i_in,
    sfc_out_if.source o_out
);
    import sfc_pkg::*;

    t_in_beat  r_s1;
    t_in_beat  n_s1;
    logic      r_s1_valid;
    t_out_beat r_out;
    t_out_beat n_out;
    logic      r_out_valid;

    logic             s2_ready;
    logic             s1_ready;
    logic             crc_ok;
    logic [RAW_W-1:0] masked;
    logic signed [VAL_W-1:0] scaled;

    assign s2_ready   = !r_out_valid || o_out.ready;
    assign s1_ready   = !r_s1_valid || s2_ready;
    assign i_in.ready = s1_ready;

    always_comb begin
        n_s1.op         = t_op'(i_in.op);
        n_s1.raw_word   = i_in.raw_word;
        n_s1.check_byte = i_in.check_byte;
        n_s1.bus_error  = i_in.bus_error;
    end

    sfc_crc u_crc (
        .i_raw_word   (r_s1.raw_word),
        .i_check_byte (r_s1.check_byte),
        .o_crc_ok     (crc_ok)
    );

    assign masked = r_s1.raw_word & STATUS_MASK;

    sfc_scale u_scale (
        .i_op     (r_s1.op),
        .i_masked (masked),
        .o_value  (scaled)
    );

    always_comb begin
        n_out.valid_res    = !r_s1.bus_error && crc_ok;
        n_out.masked_raw   = r_s1.bus_error ? '0 : masked;
        n_out.scaled_value = n_out.valid_res ? scaled : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (s2_ready) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_in.valid) begin
            r_s1 <= n_s1;
        end
        if (s2_ready && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.scaled_value = r_out.scaled_value;
    assign o_out.valid_res    = r_out.valid_res;
    assign o_out.masked_raw   = r_out.masked_raw;

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.valid_res) |-> (r_out.scaled_value == '0))
        else $error("invalid result carries nonzero value");

    a_status_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.masked_raw[1:0] == 2'b00))
        else $error("status bits not cleared");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && s2_ready) |=> r_out_valid)
        else $error("beat lost between stages");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_s1_valid && r_out_valid && !o_out.ready))
        else $error("input stalled while pipeline has room");

endmodule
